/* src/sparse_column_builder_core_defines.svh */
// Assertion macros for the sparse column builder.
// Used by the RTL files that carry assertions; no other dependencies.
`ifndef SPARSE_COLUMN_BUILDER_CORE_DEFINES_SVH
`define SPARSE_COLUMN_BUILDER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define SCB_ASSERT(lbl, prop, msg)
`define SCB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* src/scb_pkg.sv */
// Shared constants, types and arithmetic helpers of the sparse column builder.
// No dependencies.
package scb_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned MAX_COLUMNS = 64;
  localparam int unsigned MAX_ROWS    = 1024;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned CSEL_W = 6;
  localparam int unsigned ESEL_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned NCOL_W = 7;
  localparam int unsigned THR_W  = 16;

  localparam int unsigned EC_W   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CO_W   = $clog2(MAX_COLUMNS + 2);
  localparam int unsigned CS_AW  = $clog2(MAX_COLUMNS + 1);

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_OPEN  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_NOCOL  = 2'd2;
  localparam logic [1:0] STAT_BADIDX = 2'd3;

  localparam logic CFG_NUM_COLUMNS    = 1'b0;
  localparam logic CFG_ZERO_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ROW_W-1:0]  row;
    logic [VAL_W-1:0]  value;
    logic [CSEL_W-1:0] csel;
    logic [ESEL_W-1:0] esel;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] total;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [ROW_W-1:0]  row;
  } ent_wr_t;

  typedef struct packed {
    logic             we;
    logic [CS_AW-1:0] addr;
    logic [EC_W-1:0]  start;
  } cs_wr_t;

  // Q16.16 add, saturating to the signed 32-bit range
  function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return s[VAL_W-1:0];
  endfunction

  // |v| < thr, magnitude taken one bit wider so the most negative value works
  function automatic logic mag_below(logic [VAL_W-1:0] v, logic [THR_W-1:0] thr);
    logic [VAL_W:0] m;
    m = v[VAL_W-1] ? ((VAL_W+1)'(0) - {1'b1, v}) : {1'b0, v};
    return m < {{(VAL_W+1-THR_W){1'b0}}, thr};
  endfunction

endpackage

/* src/scb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/scb_ctrl.sv */
// Sequencer of the sparse column builder: decodes items, scans and shifts the
// entry stores one slot per cycle, holds counters, config and the result register.
// Depends on scb_pkg and sparse_column_builder_core_defines.svh.
`include "sparse_column_builder_core_defines.svh"

module scb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [scb_pkg::THR_W-1:0]     cfg_data_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  scb_pkg::item_t                item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output scb_pkg::result_t              res_o,
  output logic [scb_pkg::ADDR_W-1:0]    ent_raddr_o,
  input  logic [scb_pkg::VAL_W-1:0]     ent_rd_value_i,
  input  logic [scb_pkg::ROW_W-1:0]     ent_rd_row_i,
  output scb_pkg::ent_wr_t              ent_wr_o,
  output logic [scb_pkg::CS_AW-1:0]     cs_raddr_o,
  input  logic [scb_pkg::EC_W-1:0]      cs_rd_i,
  output scb_pkg::cs_wr_t               cs_wr_o
);

  localparam int unsigned EcW = scb_pkg::EC_W;
  localparam int unsigned CoW = scb_pkg::CO_W;
  localparam int unsigned AdW = scb_pkg::ADDR_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LAST = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_SHUP = 4'd4;
  localparam logic [3:0] S_INS  = 4'd5;
  localparam logic [3:0] S_SHDN = 4'd6;
  localparam logic [3:0] S_R1   = 4'd7;
  localparam logic [3:0] S_R2   = 4'd8;
  localparam logic [3:0] S_RC   = 4'd9;
  localparam logic [3:0] S_R3   = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]                   state_q, state_d;
  logic [EcW-1:0]               ec_q, ec_d;
  logic [CoW-1:0]               co_q, co_d;
  logic [EcW-1:0]               open_start_q, open_start_d;
  logic [scb_pkg::NCOL_W-1:0]   ncol_q;
  logic [scb_pkg::THR_W-1:0]    thr_q;
  scb_pkg::item_t               it_q, it_d;
  logic [EcW-1:0]               idx_q, idx_d;
  logic [EcW-1:0]               pos_q, pos_d;
  logic [scb_pkg::VAL_W-1:0]    sum_q, sum_d;
  logic [EcW-1:0]               b_q, b_d;
  logic [EcW-1:0]               e_q, e_d;
  scb_pkg::result_t             acc_q, acc_d;
  scb_pkg::result_t             res_q, res_d;
  logic                         res_valid_q, res_valid_d;

  logic [CoW-1:0]               lim;
  logic [EcW-1:0]               cnt;
  logic                         accept;
  logic                         store_full;

  assign lim = (ncol_q > scb_pkg::NCOL_W'(scb_pkg::MAX_COLUMNS)) ?
               CoW'(scb_pkg::MAX_COLUMNS) : CoW'(ncol_q);
  assign cnt = (e_q > b_q) ? (e_q - b_q) : '0;
  assign store_full = (32'(ec_q) >= scb_pkg::MAX_ENTRIES);

  assign item_ready_o = (state_q == S_IDLE);
  assign accept       = item_valid_i && item_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  always_comb begin
    state_d      = state_q;
    ec_d         = ec_q;
    co_d         = co_q;
    open_start_d = open_start_q;
    it_d         = it_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    sum_d        = sum_q;
    b_d          = b_q;
    e_d          = e_q;
    acc_d        = acc_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    ent_raddr_o  = '0;
    ent_wr_o     = '0;
    cs_raddr_o   = '0;
    cs_wr_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          it_d    = item_i;
          acc_d   = '0;
          state_d = S_FIN;
          unique case (item_i.mode)
            scb_pkg::MODE_CLEAR: begin
              ec_d = '0;
              co_d = '0;
            end
            scb_pkg::MODE_OPEN: begin
              if ({1'b0, co_q} >= ({1'b0, lim} + 1'b1)) begin
                acc_d.status = scb_pkg::STAT_NOCOL;
              end else begin
                cs_wr_o.we    = 1'b1;
                cs_wr_o.addr  = co_q[scb_pkg::CS_AW-1:0];
                cs_wr_o.start = ec_q;
                open_start_d  = ec_q;
                co_d          = co_q + 1'b1;
              end
            end
            scb_pkg::MODE_PUSH: begin
              if (co_q == '0 || co_q > lim) begin
                acc_d.status = scb_pkg::STAT_NOCOL;
              end else if (32'(item_i.row) >= scb_pkg::MAX_ROWS) begin
                acc_d.status = scb_pkg::STAT_BADIDX;
              end else if (open_start_q >= ec_q) begin
                // empty open column: plain append
                if (store_full) begin
                  acc_d.status = scb_pkg::STAT_FULL;
                end else begin
                  ent_wr_o = '{we: 1'b1, addr: ec_q[AdW-1:0],
                               value: item_i.value, row: item_i.row};
                  ec_d     = ec_q + 1'b1;
                end
              end else begin
                ent_raddr_o = AdW'(ec_q - 1'b1);
                state_d     = S_LAST;
              end
            end
            scb_pkg::MODE_READ: begin
              if (CoW'(item_i.csel) >= co_q || CoW'(item_i.csel) >= lim) begin
                acc_d.status = scb_pkg::STAT_BADIDX;
              end else begin
                cs_raddr_o = scb_pkg::CS_AW'(item_i.csel);
                state_d    = S_R1;
              end
            end
            default: ;
          endcase
        end
      end
      S_LAST: begin
        if (ent_rd_row_i < it_q.row) begin
          state_d = S_FIN;
          if (store_full) begin
            acc_d.status = scb_pkg::STAT_FULL;
          end else begin
            ent_wr_o = '{we: 1'b1, addr: ec_q[AdW-1:0],
                         value: it_q.value, row: it_q.row};
            ec_d     = ec_q + 1'b1;
          end
        end else begin
          ent_raddr_o = open_start_q[AdW-1:0];
          idx_d       = open_start_q;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ent_rd_row_i > it_q.row) begin
          if (store_full) begin
            acc_d.status = scb_pkg::STAT_FULL;
            state_d      = S_FIN;
          end else begin
            pos_d       = idx_q;
            idx_d       = ec_q - 1'b1;
            ent_raddr_o = AdW'(ec_q - 1'b1);
            state_d     = S_SHUP;
          end
        end else if (ent_rd_row_i == it_q.row) begin
          sum_d   = scb_pkg::sat_add(ent_rd_value_i, it_q.value);
          pos_d   = idx_q;
          state_d = S_ACC;
        end else begin
          idx_d       = idx_q + 1'b1;
          ent_raddr_o = AdW'(idx_q + 1'b1);
        end
      end
      S_SHUP: begin
        ent_wr_o = '{we: 1'b1, addr: AdW'(idx_q + 1'b1),
                     value: ent_rd_value_i, row: ent_rd_row_i};
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          idx_d       = idx_q - 1'b1;
          ent_raddr_o = AdW'(idx_q - 1'b1);
        end
      end
      S_INS: begin
        ent_wr_o = '{we: 1'b1, addr: pos_q[AdW-1:0], value: it_q.value, row: it_q.row};
        ec_d     = ec_q + 1'b1;
        state_d  = S_FIN;
      end
      S_ACC: begin
        if (scb_pkg::mag_below(sum_q, thr_q)) begin
          if (pos_q == ec_q - 1'b1) begin
            ec_d    = ec_q - 1'b1;
            state_d = S_FIN;
          end else begin
            idx_d       = pos_q;
            ent_raddr_o = AdW'(pos_q + 1'b1);
            state_d     = S_SHDN;
          end
        end else begin
          ent_wr_o = '{we: 1'b1, addr: pos_q[AdW-1:0], value: sum_q, row: it_q.row};
          state_d  = S_FIN;
        end
      end
      S_SHDN: begin
        ent_wr_o = '{we: 1'b1, addr: idx_q[AdW-1:0],
                     value: ent_rd_value_i, row: ent_rd_row_i};
        if (idx_q + 1'b1 == ec_q - 1'b1) begin
          ec_d    = ec_q - 1'b1;
          state_d = S_FIN;
        end else begin
          idx_d       = idx_q + 1'b1;
          ent_raddr_o = AdW'(idx_q + 2'd2);
        end
      end
      S_R1: begin
        b_d = cs_rd_i;
        if ((CoW'(it_q.csel) + 1'b1) < co_q) begin
          cs_raddr_o = scb_pkg::CS_AW'(CoW'(it_q.csel) + 1'b1);
          state_d    = S_R2;
        end else begin
          e_d     = ec_q;
          state_d = S_RC;
        end
      end
      S_R2: begin
        e_d     = cs_rd_i;
        state_d = S_RC;
      end
      S_RC: begin
        acc_d.count = scb_pkg::CNT_W'(cnt);
        if (EcW'(it_q.esel) >= cnt) begin
          acc_d.status = scb_pkg::STAT_BADIDX;
          state_d      = S_FIN;
        end else begin
          ent_raddr_o = AdW'(b_q + EcW'(it_q.esel));
          state_d     = S_R3;
        end
      end
      S_R3: begin
        acc_d.value = ent_rd_value_i;
        acc_d.row   = ent_rd_row_i;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!res_valid_q || res_ready_i) begin
          res_d       = acc_q;
          res_d.total = scb_pkg::CNT_W'(ec_q);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ec_q         <= '0;
      co_q         <= '0;
      open_start_q <= '0;
      res_valid_q  <= 1'b0;
      ncol_q       <= scb_pkg::NCOL_W'(scb_pkg::MAX_COLUMNS);
      thr_q        <= scb_pkg::THR_W'(1);
    end else begin
      state_q      <= state_d;
      ec_q         <= ec_d;
      co_q         <= co_d;
      open_start_q <= open_start_d;
      res_valid_q  <= res_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          scb_pkg::CFG_NUM_COLUMNS:    ncol_q <= cfg_data_i[scb_pkg::NCOL_W-1:0];
          scb_pkg::CFG_ZERO_THRESHOLD: thr_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    it_q  <= it_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    sum_q <= sum_d;
    b_q   <= b_d;
    e_q   <= e_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  `SCB_ASSERT(a_ec_bound, (32'(ec_q) <= scb_pkg::MAX_ENTRIES), "entry count past store depth")
  `SCB_ASSERT(a_co_bound, (32'(co_q) <= scb_pkg::MAX_COLUMNS + 1), "too many column starts")
  `SCB_ASSERT_NEXT(a_clear, (accept && item_i.mode == scb_pkg::MODE_CLEAR), (ec_q == '0 && co_q == '0), "clear did not empty store")
  `SCB_ASSERT_NEXT(a_fin_out, (state_q == S_FIN && (!res_valid_q || res_ready_i)), (res_valid_q && state_q == S_IDLE), "finished item not presented")

endmodule

/* src/sparse_column_builder_core.sv */
// Top level of the sparse column builder: stream ports, config port, entry and
// column-start memories. Depends on scb_pkg, scb_ram and scb_ctrl.
//
// Channel  Direction  Handshake          Payload
// s_*      in         tvalid / tready    tdata: item fields, tuser: mode
// m_*      out        tvalid / tready    tdata: result fields, tuser: status
// cfg_*    in         valid / ready      index 0 num_columns, 1 zero_threshold
//
// Clear, open-column and items rejected at decode go straight to the result; an append
// may first read the last entry of the open column, and a read looks up the column's
// start and end before fetching the entry. A sorted insert or a delete walks the open
// column and then moves the entries behind the slot one per cycle through the single
// read/write port pair of the entry memories. The input is not ready while an item is
// at work.
// Reset clears the counters and returns the config to its defaults; memory contents
// stay undefined and are never read before being written. A stalled output holds the
// next item's result in the sequencer until the output register frees up.

module sparse_column_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,   // row_index, entry_value, column_select, element_select
  input  logic [1:0]  s_tuser_i,   // mode
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // read_value, read_row, column_count, total_entries
  output logic [1:0]  m_tuser_o    // status
);

  scb_pkg::item_t                   item;
  scb_pkg::result_t                 res;
  scb_pkg::ent_wr_t                 ent_wr;
  scb_pkg::cs_wr_t                  cs_wr;
  logic [scb_pkg::ADDR_W-1:0]       ent_raddr;
  logic [scb_pkg::VAL_W-1:0]        ent_rd_value;
  logic [scb_pkg::ROW_W-1:0]        ent_rd_row;
  logic [scb_pkg::CS_AW-1:0]        cs_raddr;
  logic [scb_pkg::EC_W-1:0]         cs_rd;

  // config registers are always writable; the sequencer only reads them
  assign cfg_ready_o = 1'b1;

  // unpack input transfer
  assign item.mode  = s_tuser_i;
  assign item.row   = s_tdata_i[9:0];
  assign item.value = s_tdata_i[41:10];
  assign item.csel  = s_tdata_i[47:42];
  assign item.esel  = s_tdata_i[57:48];

  // pack result transfer
  assign m_tuser_o = res.status;
  assign m_tdata_o = {res.total, res.count, res.row, res.value};

  scb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_valid_i   (s_tvalid_i),
    .item_ready_o   (s_tready_o),
    .item_i         (item),
    .res_valid_o    (m_tvalid_o),
    .res_ready_i    (m_tready_i),
    .res_o          (res),
    .ent_raddr_o    (ent_raddr),
    .ent_rd_value_i (ent_rd_value),
    .ent_rd_row_i   (ent_rd_row),
    .ent_wr_o       (ent_wr),
    .cs_raddr_o     (cs_raddr),
    .cs_rd_i        (cs_rd),
    .cs_wr_o        (cs_wr)
  );

  // entry values, kept column by column in row order
  scb_ram #(.WIDTH(scb_pkg::VAL_W), .DEPTH(scb_pkg::MAX_ENTRIES)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ent_wr.we),
    .waddr_i (ent_wr.addr),
    .wdata_i (ent_wr.value),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd_value)
  );

  // entry row indices, same addressing as the values
  scb_ram #(.WIDTH(scb_pkg::ROW_W), .DEPTH(scb_pkg::MAX_ENTRIES)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ent_wr.we),
    .waddr_i (ent_wr.addr),
    .wdata_i (ent_wr.row),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd_row)
  );

  // start position of every opened column
  scb_ram #(.WIDTH(scb_pkg::EC_W), .DEPTH(scb_pkg::MAX_COLUMNS + 1)) u_cs_ram (
    .clk_i   (clk_i),
    .we_i    (cs_wr.we),
    .waddr_i (cs_wr.addr),
    .wdata_i (cs_wr.start),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rd)
  );

endmodule
